// File: rtl/glq_pkg.sv
// ---------------------------------------------------------------------------
// glq_pkg: shared types and constants for the glyph quad layout block
// Request and result payloads, scaled metric bundle, codes and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

package glq_pkg;

    localparam int MAX_QUADS = 64;
    localparam int QIDX_W    = (MAX_QUADS > 1) ? $clog2(MAX_QUADS) : 1;
    localparam int COUNT_W   = $clog2(MAX_QUADS + 1);

    localparam int POS_W     = 24;
    localparam int METRIC_W  = 20;
    localparam int ATLAS_W   = 16;
    localparam int UV_W      = 16;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    // wide enough for any sum of three position-sized terms
    localparam int SAT_IN_W  = POS_W + 3;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    // request kinds
    localparam logic [2:0] KIND_GLYPH   = 3'd0;
    localparam logic [2:0] KIND_BLANK   = 3'd1;
    localparam logic [2:0] KIND_MISSING = 3'd2;
    localparam logic [2:0] KIND_NEWLINE = 3'd3;
    localparam logic [2:0] KIND_RETURN  = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;

    // result status
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PEN_SCALE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STEP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_SPACING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_HEIGHT   = 3'd4;

    typedef struct packed {
        logic [2:0]                 kind;
        logic signed [METRIC_W-1:0] advance;
        logic signed [METRIC_W-1:0] kerning;
        logic signed [METRIC_W-1:0] plane_left;
        logic signed [METRIC_W-1:0] plane_right;
        logic signed [METRIC_W-1:0] plane_top;
        logic signed [METRIC_W-1:0] plane_bottom;
        logic [ATLAS_W-1:0]         atlas_left;
        logic [ATLAS_W-1:0]         atlas_right;
        logic [ATLAS_W-1:0]         atlas_top;
        logic [ATLAS_W-1:0]         atlas_bottom;
    } glq_in_t;

    typedef struct packed {
        logic signed [POS_W-1:0] rect_min_x;
        logic signed [POS_W-1:0] rect_min_y;
        logic signed [POS_W-1:0] rect_max_x;
        logic signed [POS_W-1:0] rect_max_y;
        logic [UV_W-1:0]         uv_min_u;
        logic [UV_W-1:0]         uv_min_v;
        logic [UV_W-1:0]         uv_max_u;
        logic [UV_W-1:0]         uv_max_v;
        logic                    last_quad;
        logic [1:0]              status;
    } glq_out_t;

    // metrics in pixels and atlas coordinates in uv units
    typedef struct packed {
        logic signed [POS_W-1:0] kern;
        logic signed [POS_W-1:0] adv;
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] right;
        logic signed [POS_W-1:0] top;
        logic signed [POS_W-1:0] bottom;
        logic [UV_W-1:0]         u_left;
        logic [UV_W-1:0]         u_right;
        logic [UV_W-1:0]         v_top;
        logic [UV_W-1:0]         v_bottom;
    } glq_scaled_t;

    function automatic logic signed [SAT_IN_W-1:0] ext_pos(input logic signed [POS_W-1:0] a);
        return {{(SAT_IN_W-POS_W){a[POS_W-1]}}, a};
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SAT_IN_W-1:0] v);
        logic [SAT_IN_W-POS_W:0] top_bits;
        top_bits = v[SAT_IN_W-1:POS_W-1];
        if ((&top_bits) || !(|top_bits))
            return v[POS_W-1:0];
        else if (v[SAT_IN_W-1])
            return POS_MIN;
        else
            return POS_MAX;
    endfunction

endpackage

`default_nettype wire

// File: rtl/glyph_quad_layout.sv
// ---------------------------------------------------------------------------
// glyph_quad_layout: pen-advance text layout with kerning and quad store
// Places looked-up glyphs, keeps their quads and emits them at end of text.
// ---------------------------------------------------------------------------
// One request per character arrives on glyph/glyph_valid/glyph_stall; the
// block holds glyph_stall high while it works on a request. A glyph with
// bounds passes acceptance, the product and result registers of the scaling
// lanes, kerning, placement and the quad store write; one without bounds
// skips the write. Newline, carriage return, missing glyph and unused kinds
// finish at acceptance. An end request emits the stored quads on
// quad/quad_valid/quad_stall, shifted so the bounds minimum is the origin,
// each by a read of the quad memory and a load of the output register;
// empty text gives one quad with status empty. After the last quad is
// loaded the layout state clears and the next request is taken while that
// quad still waits in the output register. A stalled output holds its
// quad; emission pauses until it is taken. Reset clears the pen, bounds
// and quad count and loads the register defaults; the quad memory needs
// no clearing since only entries written since the last end are read.
// Registers are written through cfg_write, cfg_index and cfg_data; the
// user must do so only while the block is idle; the block has no check.
// ---------------------------------------------------------------------------
`default_nettype none

module glyph_quad_layout
    import glq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 glyph_valid,
    output logic                      glyph_stall,
    input  wire glq_in_t              glyph,
    output logic                      quad_valid,
    input  wire logic                 quad_stall,
    output glq_out_t                  quad,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_KERN,
        S_PLACE,
        S_WRITE,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] y0;
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y1;
        logic [UV_W-1:0]         u0;
        logic [UV_W-1:0]         v0;
        logic [UV_W-1:0]         u1;
        logic [UV_W-1:0]         v1;
    } entry_t;

    // registers
    logic [CFG_W-1:0]        pen_scale_reg;
    logic [POS_W-2:0]        line_step_reg;
    logic signed [POS_W-1:0] char_spacing_reg;
    logic [CFG_W-1:0]        inv_width_reg;
    logic [CFG_W-1:0]        inv_height_reg;

    state_t                  state_reg, state_next;
    logic                    bounded_reg, bounded_next;
    logic signed [POS_W-1:0] pen_x_reg, pen_x_next;
    logic signed [POS_W-1:0] pen_y_reg, pen_y_next;
    logic                    have_prev_reg, have_prev_next;
    logic signed [POS_W-1:0] bound_min_x_reg, bound_min_x_next;
    logic signed [POS_W-1:0] bound_min_y_reg, bound_min_y_next;
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic                    overflowed_reg, overflowed_next;
    logic [COUNT_W-1:0]      emit_k_reg, emit_k_next;
    logic signed [POS_W-1:0] xa_reg, xa_next;
    logic signed [POS_W-1:0] xb_reg, xb_next;
    logic signed [POS_W-1:0] ya_reg, ya_next;
    logic signed [POS_W-1:0] yb_reg, yb_next;
    logic                    quad_valid_reg, quad_valid_next;
    glq_out_t                quad_reg, quad_next;

    entry_t                  quad_mem [MAX_QUADS];
    entry_t                  rd_data_reg;
    entry_t                  wr_data;
    logic                    mem_we;

    glq_scaled_t             scaled;
    logic                    scaled_done;
    logic                    accept;
    logic                    start;
    logic                    out_free;
    logic                    is_last;

    assign glyph_stall = (state_reg != S_IDLE);
    assign accept      = glyph_valid && !glyph_stall;
    assign start       = accept && (glyph.kind inside {KIND_GLYPH, KIND_BLANK});
    assign out_free    = !quad_valid_reg || !quad_stall;
    assign is_last     = ((emit_k_reg + COUNT_W'(1)) == count_reg);

    glq_metric_unit u_metric (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .glyph            (glyph),
        .pen_scale        (pen_scale_reg),
        .inv_atlas_width  (inv_width_reg),
        .inv_atlas_height (inv_height_reg),
        .scaled           (scaled),
        .done             (scaled_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_scale_reg    <= CFG_W'(65536);
            line_step_reg    <= '0;
            char_spacing_reg <= '0;
            inv_width_reg    <= CFG_W'(65536);
            inv_height_reg   <= CFG_W'(65536);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PEN_SCALE:    pen_scale_reg    <= cfg_data;
                CFG_LINE_STEP:    line_step_reg    <= cfg_data[POS_W-2:0];
                CFG_CHAR_SPACING: char_spacing_reg <= $signed(cfg_data);
                CFG_INV_WIDTH:    inv_width_reg    <= cfg_data;
                CFG_INV_HEIGHT:   inv_height_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            quad_mem[count_reg[QIDX_W-1:0]] <= wr_data;
        rd_data_reg <= quad_mem[emit_k_reg[QIDX_W-1:0]];
    end

    always_comb
    begin
        state_next       = state_reg;
        bounded_next     = bounded_reg;
        pen_x_next       = pen_x_reg;
        pen_y_next       = pen_y_reg;
        have_prev_next   = have_prev_reg;
        bound_min_x_next = bound_min_x_reg;
        bound_min_y_next = bound_min_y_reg;
        count_next       = count_reg;
        overflowed_next  = overflowed_reg;
        emit_k_next      = emit_k_reg;
        xa_next          = xa_reg;
        xb_next          = xb_reg;
        ya_next          = ya_reg;
        yb_next          = yb_reg;
        quad_valid_next  = quad_valid_reg;
        quad_next        = quad_reg;
        mem_we           = 1'b0;

        // sorted rectangle and uv of the glyph being stored
        wr_data.x0 = (xb_reg < xa_reg) ? xb_reg : xa_reg;
        wr_data.x1 = (xb_reg < xa_reg) ? xa_reg : xb_reg;
        wr_data.y0 = (yb_reg < ya_reg) ? yb_reg : ya_reg;
        wr_data.y1 = (yb_reg < ya_reg) ? ya_reg : yb_reg;
        wr_data.u0 = (scaled.u_right < scaled.u_left) ? scaled.u_right : scaled.u_left;
        wr_data.u1 = (scaled.u_right < scaled.u_left) ? scaled.u_left : scaled.u_right;
        wr_data.v0 = (scaled.v_bottom < scaled.v_top) ? scaled.v_bottom : scaled.v_top;
        wr_data.v1 = (scaled.v_bottom < scaled.v_top) ? scaled.v_top : scaled.v_bottom;

        if (quad_valid_reg && !quad_stall)
            quad_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (glyph.kind)
                        KIND_GLYPH, KIND_BLANK:
                        begin
                            bounded_next = (glyph.kind == KIND_GLYPH);
                            state_next   = S_SCALE;
                        end
                        KIND_NEWLINE:
                        begin
                            pen_x_next     = '0;
                            pen_y_next     = sat_pos(ext_pos(pen_y_reg)
                                                     + SAT_IN_W'(line_step_reg));
                            have_prev_next = 1'b0;
                        end
                        KIND_END:
                        begin
                            emit_k_next = '0;
                            state_next  = S_EMIT_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCALE:
            begin
                if (scaled_done)
                    state_next = S_KERN;
            end
            S_KERN:
            begin
                if (have_prev_reg)
                    pen_x_next = sat_pos(ext_pos(pen_x_reg) + ext_pos(scaled.kern));
                have_prev_next = 1'b1;
                state_next     = S_PLACE;
            end
            S_PLACE:
            begin
                xa_next    = sat_pos(ext_pos(pen_x_reg) + ext_pos(scaled.left));
                xb_next    = sat_pos(ext_pos(pen_x_reg) + ext_pos(scaled.right));
                ya_next    = sat_pos(ext_pos(pen_y_reg) + ext_pos(scaled.top));
                yb_next    = sat_pos(ext_pos(pen_y_reg) + ext_pos(scaled.bottom));
                pen_x_next = sat_pos(ext_pos(pen_x_reg) + ext_pos(scaled.adv)
                                     + ext_pos(char_spacing_reg));
                state_next = bounded_reg ? S_WRITE : S_IDLE;
            end
            S_WRITE:
            begin
                if (count_reg < COUNT_W'(MAX_QUADS))
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + COUNT_W'(1);
                    if (wr_data.x0 < bound_min_x_reg)
                        bound_min_x_next = wr_data.x0;
                    if (wr_data.y0 < bound_min_y_reg)
                        bound_min_y_next = wr_data.y0;
                end
                else
                begin
                    overflowed_next = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT:
            begin
                if (out_free)
                begin
                    quad_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        quad_next           = '0;
                        quad_next.last_quad = 1'b1;
                        quad_next.status    = STATUS_EMPTY;
                    end
                    else
                    begin
                        quad_next.rect_min_x = sat_pos(ext_pos(rd_data_reg.x0)
                                                       - ext_pos(bound_min_x_reg));
                        quad_next.rect_min_y = sat_pos(ext_pos(rd_data_reg.y0)
                                                       - ext_pos(bound_min_y_reg));
                        quad_next.rect_max_x = sat_pos(ext_pos(rd_data_reg.x1)
                                                       - ext_pos(bound_min_x_reg));
                        quad_next.rect_max_y = sat_pos(ext_pos(rd_data_reg.y1)
                                                       - ext_pos(bound_min_y_reg));
                        quad_next.uv_min_u   = rd_data_reg.u0;
                        quad_next.uv_min_v   = rd_data_reg.v0;
                        quad_next.uv_max_u   = rd_data_reg.u1;
                        quad_next.uv_max_v   = rd_data_reg.v1;
                        quad_next.last_quad  = is_last;
                        quad_next.status     = overflowed_reg ? STATUS_OVERFLOW : STATUS_OK;
                    end
                    if (count_reg == '0 || is_last)
                    begin
                        // end of text: back to a fresh layout
                        pen_x_next       = '0;
                        pen_y_next       = '0;
                        have_prev_next   = 1'b0;
                        bound_min_x_next = POS_MAX;
                        bound_min_y_next = POS_MAX;
                        count_next       = '0;
                        overflowed_next  = 1'b0;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        emit_k_next = emit_k_reg + COUNT_W'(1);
                        state_next  = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bounded_reg     <= 1'b0;
            pen_x_reg       <= '0;
            pen_y_reg       <= '0;
            have_prev_reg   <= 1'b0;
            bound_min_x_reg <= POS_MAX;
            bound_min_y_reg <= POS_MAX;
            count_reg       <= '0;
            overflowed_reg  <= 1'b0;
            emit_k_reg      <= '0;
            xa_reg          <= '0;
            xb_reg          <= '0;
            ya_reg          <= '0;
            yb_reg          <= '0;
            quad_valid_reg  <= 1'b0;
            quad_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            bounded_reg     <= bounded_next;
            pen_x_reg       <= pen_x_next;
            pen_y_reg       <= pen_y_next;
            have_prev_reg   <= have_prev_next;
            bound_min_x_reg <= bound_min_x_next;
            bound_min_y_reg <= bound_min_y_next;
            count_reg       <= count_next;
            overflowed_reg  <= overflowed_next;
            emit_k_reg      <= emit_k_next;
            xa_reg          <= xa_next;
            xb_reg          <= xb_next;
            ya_reg          <= ya_next;
            yb_reg          <= yb_next;
            quad_valid_reg  <= quad_valid_next;
            quad_reg        <= quad_next;
        end
    end

    assign quad_valid = quad_valid_reg;
    assign quad       = quad_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_QUADS))
        else $error("quad count beyond store capacity");

    a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflowed_reg |-> (count_reg == COUNT_W'(MAX_QUADS)))
        else $error("overflow flagged with free store entries");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT_RD || state_reg == S_EMIT_OUT) && count_reg != '0)
        |-> (emit_k_reg < count_reg))
        else $error("emit index past the stored quads");

    a_scaled_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        scaled_done |-> (state_reg == S_SCALE))
        else $error("scaled metrics arrived outside the wait state");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_OUT && out_free) |=> quad_valid_reg)
        else $error("emit step did not present a quad");

endmodule

`default_nettype wire

// File: rtl/glq_metric_unit.sv
// ---------------------------------------------------------------------------
// glq_metric_unit: scaling of glyph metrics and atlas coordinates
// Ten parallel lanes: multiply, then round and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module glq_metric_unit
    import glq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire glq_in_t           glyph,
    input  wire logic [CFG_W-1:0]  pen_scale,
    input  wire logic [CFG_W-1:0]  inv_atlas_width,
    input  wire logic [CFG_W-1:0]  inv_atlas_height,
    output glq_scaled_t            scaled,
    output logic                   done
);

    localparam int N_METRIC = 6;
    localparam int N_ATLAS  = 4;
    localparam int MPROD_W  = METRIC_W + CFG_W + 1;
    localparam int APROD_W  = ATLAS_W + CFG_W;
    localparam int MSHIFT   = 20;
    localparam int ASHIFT   = 12;

    logic signed [METRIC_W-1:0] metric [N_METRIC];
    logic [ATLAS_W-1:0]         atlas  [N_ATLAS];
    logic [CFG_W-1:0]           inv    [N_ATLAS];
    logic signed [CFG_W:0]      scale_s;

    logic signed [MPROD_W-1:0]  mprod_reg [N_METRIC];
    logic [APROD_W-1:0]         aprod_reg [N_ATLAS];
    logic signed [POS_W-1:0]    mres_reg  [N_METRIC];
    logic [UV_W-1:0]            ares_reg  [N_ATLAS];
    logic                       prod_valid_reg;
    logic                       done_reg;

    // Q16.28 to Q16.8, round half up with floor shift
    function automatic logic signed [POS_W-1:0] round_metric(
        input logic signed [MPROD_W-1:0] p);
        logic [MPROD_W:0] r;
        r = {p[MPROD_W-1], p} + (MPROD_W+1)'(1 << (MSHIFT - 1));
        return sat_pos({r[MPROD_W], r[MPROD_W:MSHIFT]});
    endfunction

    function automatic logic [UV_W-1:0] round_uv(input logic [APROD_W-1:0] p);
        logic [APROD_W:0] r;
        r = {1'b0, p} + (APROD_W+1)'(1 << (ASHIFT - 1));
        if (|r[APROD_W:ASHIFT+UV_W])
            return {UV_W{1'b1}};
        else
            return r[ASHIFT+UV_W-1:ASHIFT];
    endfunction

    always_comb
    begin
        metric[0] = glyph.kerning;
        metric[1] = glyph.advance;
        metric[2] = glyph.plane_left;
        metric[3] = glyph.plane_right;
        metric[4] = glyph.plane_top;
        metric[5] = glyph.plane_bottom;
        atlas[0]  = glyph.atlas_left;
        atlas[1]  = glyph.atlas_right;
        atlas[2]  = glyph.atlas_top;
        atlas[3]  = glyph.atlas_bottom;
        inv[0]    = inv_atlas_width;
        inv[1]    = inv_atlas_width;
        inv[2]    = inv_atlas_height;
        inv[3]    = inv_atlas_height;
        scale_s   = $signed({1'b0, pen_scale});
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < N_METRIC; i++)
        begin
            if (start)
                mprod_reg[i] <= metric[i] * scale_s;
            if (prod_valid_reg)
                mres_reg[i] <= round_metric(mprod_reg[i]);
        end
        for (int j = 0; j < N_ATLAS; j++)
        begin
            if (start)
                aprod_reg[j] <= atlas[j] * inv[j];
            if (prod_valid_reg)
                ares_reg[j] <= round_uv(aprod_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= start;
            done_reg       <= prod_valid_reg;
        end
    end

    always_comb
    begin
        scaled.kern     = mres_reg[0];
        scaled.adv      = mres_reg[1];
        scaled.left     = mres_reg[2];
        scaled.right    = mres_reg[3];
        scaled.top      = mres_reg[4];
        scaled.bottom   = mres_reg[5];
        scaled.u_left   = ares_reg[0];
        scaled.u_right  = ares_reg[1];
        scaled.v_top    = ares_reg[2];
        scaled.v_bottom = ares_reg[3];
    end

    assign done = done_reg;

    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("scaled result without a matching start");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid_reg |-> !start)
        else $error("new start while products still in flight");

    a_one_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

endmodule

`default_nettype wire

// File: sim/glq_layout_checker.sv
// ---------------------------------------------------------------------------
// glq_layout_checker: layout predictor and quad scoreboard
// Follows register writes and accepted requests, lays the text out on its
// own pen and quad store, and compares every emitted quad field by field.
// ---------------------------------------------------------------------------
module glq_layout_checker
    import glq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 glyph_valid,
    input  logic                 glyph_stall,
    input  glq_in_t              glyph,
    input  logic                 quad_valid,
    input  logic                 quad_stall,
    input  glq_out_t             quad,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   mismatches,
    output int                   quads_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [23:0]             scale_q;
    logic [22:0]             line_q;
    logic signed [POS_W-1:0] spacing_q;
    logic [23:0]             inv_w_q;
    logic [23:0]             inv_h_q;

    logic signed [POS_W-1:0] pen_x;
    logic signed [POS_W-1:0] pen_y;
    logic signed [POS_W-1:0] min_x;
    logic signed [POS_W-1:0] min_y;
    logic                    prev_glyph;
    logic                    dropped;
    int                      n_quads;

    logic signed [POS_W-1:0] lo_x [MAX_QUADS];
    logic signed [POS_W-1:0] lo_y [MAX_QUADS];
    logic signed [POS_W-1:0] hi_x [MAX_QUADS];
    logic signed [POS_W-1:0] hi_y [MAX_QUADS];
    logic [UV_W-1:0]         u_lo [MAX_QUADS];
    logic [UV_W-1:0]         v_lo [MAX_QUADS];
    logic [UV_W-1:0]         u_hi [MAX_QUADS];
    logic [UV_W-1:0]         v_hi [MAX_QUADS];

    glq_out_t                quads_due [$];
    glq_out_t                want;

    function automatic logic signed [POS_W-1:0] clip_pos(input longint v);
        if (v > longint'(POS_MAX))
            return POS_MAX;
        if (v < longint'(POS_MIN))
            return POS_MIN;
        return v[POS_W-1:0];
    endfunction

    // Q8.12 metric times Q8.16 scale, rounded half up to Q16.8
    function automatic logic signed [POS_W-1:0] to_pixels(input logic signed [METRIC_W-1:0] m);
        longint prod;
        prod = longint'(m) * longint'({40'd0, scale_q}) + (longint'(1) <<< 19);
        return clip_pos(prod >>> 20);
    endfunction

    function automatic logic [UV_W-1:0] to_uv(input logic [ATLAS_W-1:0] texels,
                                              input logic [23:0] inv);
        longint prod;
        prod = (longint'({48'd0, texels}) * longint'({40'd0, inv}) + 2048) >> 12;
        return (prod > 65535) ? 16'hFFFF : prod[UV_W-1:0];
    endfunction

    function automatic void clear_layout();
        pen_x      = '0;
        pen_y      = '0;
        prev_glyph = 1'b0;
        min_x      = POS_MAX;
        min_y      = POS_MAX;
        n_quads    = 0;
        dropped    = 1'b0;
    endfunction

    task automatic compare_field(input string field, input logic signed [24:0] want_v,
                                 input logic signed [24:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
            mismatches++;
        end
    endtask

    task automatic lay_out_char(input glq_in_t c);
        logic signed [POS_W-1:0] step;
        logic signed [POS_W-1:0] x0;
        logic signed [POS_W-1:0] x1;
        logic signed [POS_W-1:0] y0;
        logic signed [POS_W-1:0] y1;
        logic signed [POS_W-1:0] t;
        logic [UV_W-1:0]         u0;
        logic [UV_W-1:0]         u1;
        logic [UV_W-1:0]         v0;
        logic [UV_W-1:0]         v1;
        logic [UV_W-1:0]         s;
        glq_out_t                item;
        case (c.kind)
            KIND_GLYPH, KIND_BLANK:
            begin
                step = to_pixels(c.advance);
                if (prev_glyph)
                    pen_x = clip_pos(longint'(pen_x) + to_pixels(c.kerning));
                prev_glyph = 1'b1;
                if (c.kind == KIND_GLYPH)
                begin
                    x0 = clip_pos(longint'(pen_x) + to_pixels(c.plane_left));
                    x1 = clip_pos(longint'(pen_x) + to_pixels(c.plane_right));
                    y0 = clip_pos(longint'(pen_y) + to_pixels(c.plane_top));
                    y1 = clip_pos(longint'(pen_y) + to_pixels(c.plane_bottom));
                    u0 = to_uv(c.atlas_left, inv_w_q);
                    u1 = to_uv(c.atlas_right, inv_w_q);
                    v0 = to_uv(c.atlas_top, inv_h_q);
                    v1 = to_uv(c.atlas_bottom, inv_h_q);
                    if (x1 < x0)
                    begin
                        t = x0; x0 = x1; x1 = t;
                    end
                    if (y1 < y0)
                    begin
                        t = y0; y0 = y1; y1 = t;
                    end
                    if (u1 < u0)
                    begin
                        s = u0; u0 = u1; u1 = s;
                    end
                    if (v1 < v0)
                    begin
                        s = v0; v0 = v1; v1 = s;
                    end
                    if (n_quads < MAX_QUADS)
                    begin
                        lo_x[n_quads] = x0;
                        lo_y[n_quads] = y0;
                        hi_x[n_quads] = x1;
                        hi_y[n_quads] = y1;
                        u_lo[n_quads] = u0;
                        v_lo[n_quads] = v0;
                        u_hi[n_quads] = u1;
                        v_hi[n_quads] = v1;
                        n_quads++;
                        if (x0 < min_x)
                            min_x = x0;
                        if (y0 < min_y)
                            min_y = y0;
                    end
                    else
                        dropped = 1'b1;
                end
                pen_x = clip_pos(longint'(pen_x) + step + spacing_q);
            end
            KIND_NEWLINE:
            begin
                pen_x      = '0;
                pen_y      = clip_pos(longint'(pen_y) + longint'({41'd0, line_q}));
                prev_glyph = 1'b0;
            end
            KIND_END:
            begin
                if (n_quads == 0)
                begin
                    item           = '0;
                    item.last_quad = 1'b1;
                    item.status    = STATUS_EMPTY;
                    quads_due      = {quads_due, item};
                end
                else
                begin
                    for (int k = 0; k < n_quads; k++)
                    begin
                        item.rect_min_x = clip_pos(longint'(lo_x[k]) - min_x);
                        item.rect_min_y = clip_pos(longint'(lo_y[k]) - min_y);
                        item.rect_max_x = clip_pos(longint'(hi_x[k]) - min_x);
                        item.rect_max_y = clip_pos(longint'(hi_y[k]) - min_y);
                        item.uv_min_u   = u_lo[k];
                        item.uv_min_v   = v_lo[k];
                        item.uv_max_u   = u_hi[k];
                        item.uv_max_v   = v_hi[k];
                        item.last_quad  = (k == n_quads - 1);
                        item.status     = dropped ? STATUS_OVERFLOW : STATUS_OK;
                        quads_due       = {quads_due, item};
                    end
                end
                clear_layout();
            end
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            scale_q   = 24'd65536;
            line_q    = '0;
            spacing_q = '0;
            inv_w_q   = 24'd65536;
            inv_h_q   = 24'd65536;
            clear_layout();
            quads_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PEN_SCALE:    scale_q   = cfg_data;
                    CFG_LINE_STEP:    line_q    = cfg_data[22:0];
                    CFG_CHAR_SPACING: spacing_q = cfg_data;
                    CFG_INV_WIDTH:    inv_w_q   = cfg_data;
                    CFG_INV_HEIGHT:   inv_h_q   = cfg_data;
                    default: ;
                endcase
            end
            if (quad_valid && !quad_stall)
            begin
                if (quads_due.size() == 0)
                begin
                    $error("quad emitted with no end request behind it");
                    mismatches++;
                end
                else
                begin
                    want = quads_due.pop_front();
                    compare_field("rect_min_x", want.rect_min_x, quad.rect_min_x);
                    compare_field("rect_min_y", want.rect_min_y, quad.rect_min_y);
                    compare_field("rect_max_x", want.rect_max_x, quad.rect_max_x);
                    compare_field("rect_max_y", want.rect_max_y, quad.rect_max_y);
                    compare_field("uv_min_u", want.uv_min_u, quad.uv_min_u);
                    compare_field("uv_min_v", want.uv_min_v, quad.uv_min_v);
                    compare_field("uv_max_u", want.uv_max_u, quad.uv_max_u);
                    compare_field("uv_max_v", want.uv_max_v, quad.uv_max_v);
                    compare_field("last_quad", want.last_quad, quad.last_quad);
                    compare_field("status", want.status, quad.status);
                end
            end
            if (glyph_valid && !glyph_stall)
                lay_out_char(glyph);
        end
        quads_owed = quads_due.size();
    end

endmodule

// File: sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: testbench for glyph_quad_layout
// Feeds directed and random character requests under several register
// settings, with random gaps and stalls on both channels, and reports the
// verdict of the layout checker.
// ---------------------------------------------------------------------------
module tb_top
    import glq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;

    localparam logic signed [METRIC_W-1:0] M_MAX = {1'b0, {(METRIC_W-1){1'b1}}};
    localparam logic signed [METRIC_W-1:0] M_MIN = {1'b1, {(METRIC_W-1){1'b0}}};

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 200000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 glyph_valid;
    logic                 glyph_stall;
    glq_in_t              glyph;
    logic                 quad_valid;
    logic                 quad_stall;
    glq_out_t             quad;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int quads_owed;
    int cycle_count = 0;
    bit steady      = 1'b0;
    bit hold_quads  = 1'b0;

    glyph_quad_layout i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph       (glyph),
        .quad_valid  (quad_valid),
        .quad_stall  (quad_stall),
        .quad        (quad),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    glq_layout_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .glyph_valid (glyph_valid),
        .glyph_stall (glyph_stall),
        .glyph       (glyph),
        .quad_valid  (quad_valid),
        .quad_stall  (quad_stall),
        .quad        (quad),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .quads_owed  (quads_owed)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("glyph_quad_layout verification failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        return steady ? 0 : int'($urandom_range(0, 8));
    endfunction

    // mostly a few pixels, now and then any 20-bit pattern
    function automatic logic signed [METRIC_W-1:0] rand_metric();
        if ($urandom_range(0, 7) == 0)
            return METRIC_W'($urandom);
        return METRIC_W'($urandom_range(0, 131072) - 65536);
    endfunction

    function automatic glq_in_t random_char(input logic [2:0] kind);
        glq_in_t c;
        c.kind         = kind;
        c.advance      = rand_metric();
        c.kerning      = rand_metric();
        c.plane_left   = rand_metric();
        c.plane_right  = rand_metric();
        c.plane_top    = rand_metric();
        c.plane_bottom = rand_metric();
        c.atlas_left   = ATLAS_W'($urandom);
        c.atlas_right  = ATLAS_W'($urandom);
        c.atlas_top    = ATLAS_W'($urandom);
        c.atlas_bottom = ATLAS_W'($urandom);
        return c;
    endfunction

    function automatic glq_in_t glyph_of(input logic [2:0] kind,
                                         input logic signed [METRIC_W-1:0] adv, kern,
                                         input logic signed [METRIC_W-1:0] pl, pr, pt, pb,
                                         input logic [ATLAS_W-1:0] al, ar, at, ab);
        glq_in_t c;
        c.kind         = kind;
        c.advance      = adv;
        c.kerning      = kern;
        c.plane_left   = pl;
        c.plane_right  = pr;
        c.plane_top    = pt;
        c.plane_bottom = pb;
        c.atlas_left   = al;
        c.atlas_right  = ar;
        c.atlas_top    = at;
        c.atlas_bottom = ab;
        return c;
    endfunction

    function automatic logic [2:0] pick_kind();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return KIND_GLYPH;
        if (roll < 72)
            return KIND_BLANK;
        if (roll < 78)
            return KIND_MISSING;
        if (roll < 86)
            return KIND_NEWLINE;
        if (roll < 92)
            return KIND_RETURN;
        return (roll < 96) ? KIND_SPARE6 : KIND_SPARE7;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic offer(input glq_in_t req);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            glyph_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        glyph       <= req;
        glyph_valid <= 1'b1;
        @(posedge clk);
        while (glyph_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender stops until every quad owed has come, then lets the block go idle
    task automatic settle();
        glyph_valid <= 1'b0;
        @(negedge clk);
        while (quads_owed != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] scale, line, spacing, inv_w, inv_h);
        logic [CFG_W-1:0]     vals [5];
        logic [CFG_IDX_W-1:0] regs [5];
        vals = '{scale, line, spacing, inv_w, inv_h};
        regs = '{CFG_PEN_SCALE, CFG_LINE_STEP, CFG_CHAR_SPACING, CFG_INV_WIDTH,
                 CFG_INV_HEIGHT};
        for (int i = 0; i < 5; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // result side: a drawn wait before each quad, or one long hold-off on request
    initial
    begin
        int wait_n;
        bit held;
        held       = 1'b0;
        quad_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_quads && !held)
            begin
                wait_n = HOLD_CYCLES;
                held   = 1'b1;
            end
            else
                wait_n = draw_gap();
            if (wait_n > 0)
            begin
                quad_stall <= 1'b1;
                repeat (wait_n) @(negedge clk);
            end
            quad_stall <= 1'b0;
            @(posedge clk);
            while (!quad_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        int len;
        rst_n       = 1'b0;
        glyph_valid = 1'b0;
        glyph       = '0;
        cfg_write   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed requests on the reset settings
        offer(random_char(KIND_END));
        offer(glyph_of(KIND_GLYPH, M_MAX, M_MIN, M_MAX, M_MIN, M_MIN, M_MAX,
                       16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
        offer(glyph_of(KIND_GLYPH, M_MIN, M_MIN, 20'sd0, 20'sd4096, -20'sd8192, 20'sd0,
                       16'd16, 16'd32, 16'd48, 16'd64));
        offer(random_char(KIND_MISSING));
        offer(glyph_of(KIND_GLYPH, 20'sd8192, M_MAX, 20'sd0, 20'sd4096, 20'sd0, M_MIN,
                       16'hFFFF, 16'hFFFF, 16'd1, 16'd2));
        offer(random_char(KIND_RETURN));
        offer(glyph_of(KIND_BLANK, 20'sd12288, -20'sd4096, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
                       16'd0, 16'd0, 16'd0, 16'd0));
        offer(random_char(KIND_NEWLINE));
        // no earlier glyph on this line, so the kerning is dropped
        offer(glyph_of(KIND_GLYPH, 20'sd4096, M_MAX, 20'sd256, 20'sd3072, -20'sd4096,
                       20'sd1024, 16'd100, 16'd200, 16'd300, 16'd400));
        offer(random_char(KIND_SPARE6));
        offer(random_char(KIND_SPARE7));
        offer(random_char(KIND_END));
        offer(random_char(KIND_BLANK));
        offer(random_char(KIND_END));
        offer(glyph_of(KIND_GLYPH, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0,
                       16'd0, 16'd0, 16'd0, 16'd0));
        offer(random_char(KIND_END));
        offer(random_char(KIND_NEWLINE));
        offer(random_char(KIND_GLYPH));
        offer(random_char(KIND_END));

        for (int phase = 0; phase < 6; phase++)
        begin
            settle();
            case (phase)
                0: set_config(24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF);
                1: set_config(24'h000000, 24'h000000, 24'h7FFFFF, 24'h000000, 24'h000000);
                5: set_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                              CFG_W'($urandom), CFG_W'($urandom));
                default:
                    set_config(CFG_W'($urandom_range(16384, 262144)),
                               CFG_W'($urandom_range(0, 32768)),
                               CFG_W'($urandom_range(0, 2048) - 1024),
                               CFG_W'($urandom_range(1024, 16384)),
                               CFG_W'($urandom_range(1024, 16384)));
            endcase
            steady = (phase == 3);
            if (phase == 2)
            begin
                // past the store capacity; the result side then holds off for a long
                // stretch while further requests queue up behind the emission
                hold_quads = 1'b1;
                for (int i = 0; i < 72; i++)
                    offer(random_char((i % 17 == 16) ? KIND_NEWLINE : KIND_GLYPH));
                offer(random_char(KIND_END));
            end
            for (int t = 0; t < 2; t++)
            begin
                len = $urandom_range(0, 4);
                for (int i = 0; i < len; i++)
                    offer(random_char(pick_kind()));
                offer(random_char(KIND_END));
                if (phase == 4 && t == 0)
                    settle();
            end
        end

        settle();
        if (mismatches == 0)
            $display("glyph_quad_layout verification clean");
        else
            $display("glyph_quad_layout verification failed");
        $finish;
    end

endmodule
